// ===== rtl/core/sp3d_pkg.sv =====
// Shared types and constants of the 3-D sandpile relaxation unit.
// No dependencies.
package sp3d_pkg;

    // Operation codes carried by a request item
    localparam logic OP_DROP = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Fixed field widths of the item payloads
    localparam int GRAIN_W  = 20;
    localparam int COORD_W  = 5;
    localparam int EXTENT_W = 4;
    localparam int RADIUS_W = 4;

    // A cell topples at this many grains
    localparam int TOPPLE_AT = 6;

    typedef logic [GRAIN_W-1:0]  grain_t;
    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [EXTENT_W-1:0] extent_t;
    typedef logic [RADIUS_W-1:0] radius_t;

endpackage

// ===== rtl/core/sp3d_if.sv =====
// Valid/ready channel interfaces for request and response items.
// Depends on sp3d_pkg.
interface sp3d_req_if;
    logic            valid;
    logic            ready;
    logic            operation;
    sp3d_pkg::grain_t grain_count;
    sp3d_pkg::coord_t cell_x;
    sp3d_pkg::coord_t cell_y;
    sp3d_pkg::coord_t cell_z;

    modport source (output valid, operation, grain_count, cell_x, cell_y, cell_z,
                    input ready);
    modport sink   (input valid, operation, grain_count, cell_x, cell_y, cell_z,
                    output ready);
endinterface

interface sp3d_rsp_if;
    logic              valid;
    logic              ready;
    sp3d_pkg::grain_t  cell_value;
    sp3d_pkg::extent_t extent_radius;
    logic              overflow;

    modport source (output valid, cell_value, extent_radius, overflow, input ready);
    modport sink   (input valid, cell_value, extent_radius, overflow, output ready);
endinterface

// ===== rtl/core/sandpile_3d_relaxation_unit.sv =====
// Top level of the 3-D six-neighbour sandpile relaxation unit.
// Depends on sp3d_pkg and the channel interfaces in sp3d_if.sv.
//
//  channel    | dir | contents
//  req        | in  | operation, grain_count, cell_x, cell_y, cell_z
//  rsp        | out | cell_value, extent_radius, overflow
//  cfg_we/wd  | in  | radius_in_use write
//
// One item at a time. A read registers the memory word, then the response, and
// waits on rsp.ready. A drop clears the whole grid memory (2^(3*ceil(log2
// GRID_SIDE)) words, 32768 by default), seeds the centre, then sweeps the
// toppled box until a sweep sees no topple: each cell visited is read and tested,
// and a toppling cell writes back its remainder, then reads each neighbour
// inside the cube and adds its share, all through the single grid memory port.
// After reset the same clearing pass runs before the first item is taken.
// A finished response holds in its register until taken.
module sandpile_3d_relaxation_unit #(
    parameter int GRID_SIDE = 32,
    parameter int CELL_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    sp3d_req_if.sink            req,
    sp3d_rsp_if.source          rsp,
    input  logic                cfg_we,
    input  sp3d_pkg::radius_t   cfg_wdata
);

    localparam int AW    = $clog2(GRID_SIDE);
    localparam int MW    = 3 * AW;
    localparam int DEPTH = 1 << MW;
    localparam int RMAX  = (GRID_SIDE - 3) / 2;
    localparam int VW    = (CELL_BITS > sp3d_pkg::GRAIN_W) ? CELL_BITS : sp3d_pkg::GRAIN_W;
    localparam logic [63:0] RECIP64 = ((64'd1 << CELL_BITS) + 64'd5) / 64'd6;
    localparam logic [CELL_BITS-1:0] RECIP    = RECIP64[CELL_BITS-1:0];
    localparam logic [VW-1:0]        CELL_MAX = VW'((64'd1 << CELL_BITS) - 64'd1);
    localparam logic [VW-1:0]        OUT_MAX  = VW'((64'd1 << sp3d_pkg::GRAIN_W) - 64'd1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RWAIT = 4'd2;
    localparam logic [3:0] S_RESP  = 4'd3;
    localparam logic [3:0] S_SEED  = 4'd4;
    localparam logic [3:0] S_SWEEP = 4'd5;
    localparam logic [3:0] S_CRD   = 4'd6;
    localparam logic [3:0] S_CWAIT = 4'd7;
    localparam logic [3:0] S_CTOP  = 4'd8;
    localparam logic [3:0] S_NRD   = 4'd9;
    localparam logic [3:0] S_NWAIT = 4'd10;
    localparam logic [3:0] S_NEXT  = 4'd11;

    // Grid memory
    logic [CELL_BITS-1:0] grid_mem [DEPTH];
    logic [CELL_BITS-1:0] rd_data_reg;
    logic                 mem_we;
    logic [MW-1:0]        mem_waddr;
    logic [MW-1:0]        mem_raddr;
    logic [CELL_BITS-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= grid_mem[mem_raddr];
    end

    // Control and datapath registers
    logic [3:0]              state_reg, state_next;
    sp3d_pkg::radius_t       radius_reg;
    logic [MW-1:0]           clr_addr_reg;
    logic                    drop_pend_reg;
    logic [CELL_BITS-1:0]    seed_reg;
    logic [AW-1:0]           side_m1_reg, centre_reg;
    logic [AW-1:0]           bx_lo_reg, bx_hi_reg, by_lo_reg, by_hi_reg, bz_lo_reg, bz_hi_reg;
    logic [AW-1:0]           sx_hi_reg, sy_lo_reg, sy_hi_reg, sz_lo_reg, sz_hi_reg;
    logic [AW-1:0]           cx_reg, cy_reg, cz_reg;
    logic [2:0]              nb_reg;
    logic                    lost_reg, changed_reg;
    logic                    rd_zero_reg;
    logic [CELL_BITS-1:0]    v_reg, t_reg;
    logic [2*CELL_BITS-1:0]  prod_reg;
    sp3d_pkg::grain_t        cell_value_reg;
    sp3d_pkg::extent_t       extent_reg;
    logic                    overflow_reg;

    // Radius clamp and derived geometry
    logic [7:0] r_clamp;
    always_comb
    begin
        r_clamp = 8'(radius_reg);
        if (r_clamp < 8'd1)
        begin
            r_clamp = 8'd1;
        end
        if (r_clamp > 8'(RMAX))
        begin
            r_clamp = 8'(RMAX);
        end
    end

    // Seed value, saturated to the cell maximum
    logic [VW-1:0] grain_wide;
    logic [CELL_BITS-1:0] seed_val;
    always_comb
    begin
        grain_wide = VW'(req.grain_count);
        seed_val   = (grain_wide > CELL_MAX) ? CELL_MAX[CELL_BITS-1:0]
                                             : grain_wide[CELL_BITS-1:0];
    end

    // Quotient by six from the reciprocal product, one correction step
    logic [CELL_BITS-1:0] q_raw, q_fix, rem;
    logic [CELL_BITS+2:0] q6;
    always_comb
    begin
        q_raw = prod_reg[2*CELL_BITS-1:CELL_BITS];
        q6    = (CELL_BITS+3)'(q_raw) * (CELL_BITS+3)'(sp3d_pkg::TOPPLE_AT);
        q_fix = (q6 > (CELL_BITS+3)'(v_reg)) ? q_raw - CELL_BITS'(1) : q_raw;
        rem   = v_reg - CELL_BITS'(q_fix * CELL_BITS'(sp3d_pkg::TOPPLE_AT));
    end

    // Neighbour address and border test
    logic [AW-1:0] nx, ny, nz;
    logic          nb_out;
    always_comb
    begin
        nx = cx_reg;
        ny = cy_reg;
        nz = cz_reg;
        nb_out = 1'b0;
        case (nb_reg)
            3'd0:    begin nb_out = (cx_reg == '0);          nx = cx_reg - AW'(1); end
            3'd1:    begin nb_out = (cx_reg == side_m1_reg); nx = cx_reg + AW'(1); end
            3'd2:    begin nb_out = (cy_reg == '0);          ny = cy_reg - AW'(1); end
            3'd3:    begin nb_out = (cy_reg == side_m1_reg); ny = cy_reg + AW'(1); end
            3'd4:    begin nb_out = (cz_reg == '0);          nz = cz_reg - AW'(1); end
            default: begin nb_out = (cz_reg == side_m1_reg); nz = cz_reg + AW'(1); end
        endcase
    end

    // Saturating add of the share
    logic [CELL_BITS:0] add_sum;
    assign add_sum = {1'b0, rd_data_reg} + {1'b0, t_reg};

    // Read address range check
    logic req_oob;
    assign req_oob = (32'(req.cell_x) >= GRID_SIDE) || (32'(req.cell_y) >= GRID_SIDE)
                  || (32'(req.cell_z) >= GRID_SIDE);

    // Response value saturation and extent
    logic [VW-1:0] rd_wide;
    logic [7:0]    ext_w;
    assign rd_wide = VW'(rd_data_reg);
    assign ext_w   = 8'(bx_hi_reg - bx_lo_reg) >> 1;

    // Memory port steering
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {cx_reg, cy_reg, cz_reg};
        mem_wdata = '0;
        mem_raddr = {cx_reg, cy_reg, cz_reg};
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
            end
            S_IDLE:
            begin
                mem_raddr = {AW'(req.cell_x), AW'(req.cell_y), AW'(req.cell_z)};
            end
            S_SEED:
            begin
                mem_we    = 1'b1;
                mem_waddr = {centre_reg, centre_reg, centre_reg};
                mem_wdata = seed_reg;
            end
            S_CTOP:
            begin
                mem_we    = 1'b1;
                mem_wdata = rem;
            end
            S_NRD:
            begin
                mem_raddr = {nx, ny, nz};
            end
            S_NWAIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = {nx, ny, nz};
                mem_wdata = add_sum[CELL_BITS] ? {CELL_BITS{1'b1}} : add_sum[CELL_BITS-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Next state
    logic sweep_last;
    assign sweep_last = (cz_reg == sz_hi_reg) && (cy_reg == sy_hi_reg) && (cx_reg == sx_hi_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == {MW{1'b1}})
                begin
                    state_next = drop_pend_reg ? S_SEED : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.operation == sp3d_pkg::OP_READ) ? S_RWAIT : S_CLEAR;
                end
            end
            S_RWAIT: state_next = S_RESP;
            S_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEED:  state_next = S_SWEEP;
            S_SWEEP: state_next = S_CRD;
            S_CRD:   state_next = S_CWAIT;
            S_CWAIT:
            begin
                state_next = (rd_data_reg < CELL_BITS'(sp3d_pkg::TOPPLE_AT)) ? S_NEXT : S_CTOP;
            end
            S_CTOP:  state_next = S_NRD;
            S_NRD:
            begin
                if (!nb_out)
                begin
                    state_next = S_NWAIT;
                end
                else if (nb_reg == 3'd5)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NWAIT: state_next = (nb_reg == 3'd5) ? S_NEXT : S_NRD;
            S_NEXT:
            begin
                if (!sweep_last)
                begin
                    state_next = S_CRD;
                end
                else
                begin
                    state_next = changed_reg ? S_SWEEP : S_RESP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            radius_reg    <= sp3d_pkg::RADIUS_W'(14);
            clr_addr_reg  <= '0;
            drop_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + MW'(1);
            end
            if (state_reg == S_IDLE && req.valid)
            begin
                drop_pend_reg <= (req.operation == sp3d_pkg::OP_DROP);
                clr_addr_reg  <= '0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                seed_reg    <= seed_val;
                side_m1_reg <= AW'(2 * r_clamp + 8'd2);
                centre_reg  <= AW'(r_clamp + 8'd1);
                rd_zero_reg <= req_oob;
            end
            S_RWAIT:
            begin
                if (rd_zero_reg)
                begin
                    cell_value_reg <= '0;
                end
                else
                begin
                    cell_value_reg <= (rd_wide > OUT_MAX) ? OUT_MAX[sp3d_pkg::GRAIN_W-1:0]
                                                          : rd_wide[sp3d_pkg::GRAIN_W-1:0];
                end
                extent_reg   <= '0;
                overflow_reg <= 1'b0;
            end
            S_SEED:
            begin
                bx_lo_reg <= centre_reg;
                bx_hi_reg <= centre_reg;
                by_lo_reg <= centre_reg;
                by_hi_reg <= centre_reg;
                bz_lo_reg <= centre_reg;
                bz_hi_reg <= centre_reg;
                lost_reg  <= 1'b0;
            end
            S_SWEEP:
            begin
                sx_hi_reg   <= bx_hi_reg;
                sy_lo_reg   <= by_lo_reg;
                sy_hi_reg   <= by_hi_reg;
                sz_lo_reg   <= bz_lo_reg;
                sz_hi_reg   <= bz_hi_reg;
                cx_reg      <= bx_lo_reg;
                cy_reg      <= by_lo_reg;
                cz_reg      <= bz_lo_reg;
                changed_reg <= 1'b0;
            end
            S_CWAIT:
            begin
                v_reg    <= rd_data_reg;
                prod_reg <= (2*CELL_BITS)'(rd_data_reg) * (2*CELL_BITS)'(RECIP);
            end
            S_CTOP:
            begin
                t_reg       <= q_fix;
                nb_reg      <= 3'd0;
                changed_reg <= 1'b1;
                // grow the toppled box, clamped to the active cube
                if (cx_reg != '0 && (cx_reg - AW'(1)) < bx_lo_reg) bx_lo_reg <= cx_reg - AW'(1);
                if (cx_reg != side_m1_reg && (cx_reg + AW'(1)) > bx_hi_reg)
                    bx_hi_reg <= cx_reg + AW'(1);
                if (cy_reg != '0 && (cy_reg - AW'(1)) < by_lo_reg) by_lo_reg <= cy_reg - AW'(1);
                if (cy_reg != side_m1_reg && (cy_reg + AW'(1)) > by_hi_reg)
                    by_hi_reg <= cy_reg + AW'(1);
                if (cz_reg != '0 && (cz_reg - AW'(1)) < bz_lo_reg) bz_lo_reg <= cz_reg - AW'(1);
                if (cz_reg != side_m1_reg && (cz_reg + AW'(1)) > bz_hi_reg)
                    bz_hi_reg <= cz_reg + AW'(1);
            end
            S_NRD:
            begin
                if (nb_out)
                begin
                    lost_reg <= 1'b1;
                    nb_reg   <= nb_reg + 3'd1;
                end
            end
            S_NWAIT:
            begin
                nb_reg <= nb_reg + 3'd1;
            end
            S_NEXT:
            begin
                // step the cursor, z fastest
                if (cz_reg != sz_hi_reg)
                begin
                    cz_reg <= cz_reg + AW'(1);
                end
                else if (cy_reg != sy_hi_reg)
                begin
                    cz_reg <= sz_lo_reg;
                    cy_reg <= cy_reg + AW'(1);
                end
                else if (cx_reg != sx_hi_reg)
                begin
                    cz_reg <= sz_lo_reg;
                    cy_reg <= sy_lo_reg;
                    cx_reg <= cx_reg + AW'(1);
                end
                cell_value_reg <= '0;
                extent_reg     <= (ext_w > 8'd15) ? 4'd15 : ext_w[3:0];
                overflow_reg   <= lost_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Channel outputs
    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = (state_reg == S_RESP);
    assign rsp.cell_value    = cell_value_reg;
    assign rsp.extent_radius = extent_reg;
    assign rsp.overflow      = overflow_reg;

endmodule

// ===== sim/sandpile_3d_relaxation_unit_tb.sv =====
// Self-checking testbench for sandpile_3d_relaxation_unit: drop/read items with random idling.
// A scoreboard class relaxes its own grid copy and checks every response item.
// Depends on sp3d_pkg, sp3d_if.sv and the unit itself.
module sandpile_3d_relaxation_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE_MAX   = 32;
    localparam int CELL_LIMIT = (1 << 20) - 1;
    localparam int RAD_LIMIT  = (SIDE_MAX - 3) / 2;
    localparam int STALL_MAX  = 20000000;

    typedef struct {
        sp3d_pkg::grain_t  value;
        sp3d_pkg::extent_t extent;
        logic              lost;
    } rsp_item_t;

    // Scoreboard: own grid, radius and queue of expected response items
    class sandpile_scoreboard;
        int unsigned grains[SIDE_MAX*SIDE_MAX*SIDE_MAX];
        int          radius;
        rsp_item_t   awaited[$];
        int          errors;
        int          bx0, bx1, by0, by1, bz0, bz1;
        bit          spilled;

        function new();
            foreach (grains[i]) grains[i] = 0;
            radius = 14;
            errors = 0;
        endfunction

        function int cell_index(int x, int y, int z);
            return (x * SIDE_MAX + y) * SIDE_MAX + z;
        endfunction

        function void pour(int x, int y, int z, int unsigned amount, int side);
            int unsigned v;
            if (x < 0 || y < 0 || z < 0 || x >= side || y >= side || z >= side)
            begin
                spilled = 1;
                return;
            end
            v = grains[cell_index(x, y, z)];
            grains[cell_index(x, y, z)] = (amount > CELL_LIMIT - v) ? CELL_LIMIT : v + amount;
        endfunction

        function void stretch(int p, int side, ref int lo, ref int hi);
            int a;
            int b;
            a = (p > 0) ? p - 1 : 0;
            b = (p + 1 < side) ? p + 1 : side - 1;
            if (a < lo) lo = a;
            if (b > hi) hi = b;
        endfunction

        // Clear, drop on the centre and relax until a sweep sees no topple
        function rsp_item_t relax(int unsigned g);
            rsp_item_t   res;
            int          r, side, c, x, y, z, ext;
            int unsigned v, t;
            bit          toppled;
            r = radius;
            if (r < 1) r = 1;
            if (r > RAD_LIMIT) r = RAD_LIMIT;
            side = 2 * r + 3;
            c = r + 1;
            foreach (grains[i]) grains[i] = 0;
            grains[cell_index(c, c, c)] = g;
            bx0 = c; bx1 = c; by0 = c; by1 = c; bz0 = c; bz1 = c;
            spilled = 0;
            do
            begin
                toppled = 0;
                for (x = bx0; x <= bx1; x++)
                    for (y = by0; y <= by1; y++)
                        for (z = bz0; z <= bz1; z++)
                        begin
                            v = grains[cell_index(x, y, z)];
                            if (v >= sp3d_pkg::TOPPLE_AT)
                            begin
                                t = v / sp3d_pkg::TOPPLE_AT;
                                grains[cell_index(x, y, z)] = v - t * sp3d_pkg::TOPPLE_AT;
                                pour(x - 1, y, z, t, side);
                                pour(x + 1, y, z, t, side);
                                pour(x, y - 1, z, t, side);
                                pour(x, y + 1, z, t, side);
                                pour(x, y, z - 1, t, side);
                                pour(x, y, z + 1, t, side);
                                stretch(x, side, bx0, bx1);
                                stretch(y, side, by0, by1);
                                stretch(z, side, bz0, bz1);
                                toppled = 1;
                            end
                        end
            end
            while (toppled);
            ext = (bx1 - bx0) / 2;
            res.value  = '0;
            res.extent = (ext > 15) ? 4'd15 : sp3d_pkg::extent_t'(ext);
            res.lost   = spilled;
            return res;
        endfunction

        function void note_request(logic op, sp3d_pkg::grain_t g, sp3d_pkg::coord_t x,
                                   sp3d_pkg::coord_t y, sp3d_pkg::coord_t z);
            rsp_item_t res;
            if (op == sp3d_pkg::OP_READ)
            begin
                res.value  = sp3d_pkg::grain_t'(grains[cell_index(x, y, z)]);
                res.extent = '0;
                res.lost   = 1'b0;
            end
            else
                res = relax(g);
            awaited.push_back(res);
        endfunction

        function void check_result(sp3d_pkg::grain_t v, sp3d_pkg::extent_t e, logic o);
            rsp_item_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected response item value=%0d extent=%0d overflow=%0b",
                         $time, v, e, o);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (v !== want.value)
            begin
                $display("%0t: cell_value expected %0d actual %0d", $time, want.value, v);
                errors++;
            end
            if (e !== want.extent)
            begin
                $display("%0t: extent_radius expected %0d actual %0d", $time, want.extent, e);
                errors++;
            end
            if (o !== want.lost)
            begin
                $display("%0t: overflow expected %0b actual %0b", $time, want.lost, o);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    sp3d_pkg::radius_t cfg_wdata;

    sp3d_req_if req ();
    sp3d_rsp_if rsp ();

    sandpile_3d_relaxation_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    sandpile_scoreboard sb = new();
    bit no_idle;
    int stall_count = 0;

    // Clock: 4 ns period
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Mostly short gaps, a few long ones
    function int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Response side: ready stretches and stalls
    initial
    begin
        int gap;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp.ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                rsp.ready = 1'b1;
        end
    end

    // Check response items at the rising edge
    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result(rsp.cell_value, rsp.extent_radius, rsp.overflow);

    // Watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count > STALL_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(logic op, sp3d_pkg::grain_t g, sp3d_pkg::coord_t x,
                             sp3d_pkg::coord_t y, sp3d_pkg::coord_t z);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req.valid       = 1'b1;
        req.operation   = op;
        req.grain_count = g;
        req.cell_x      = x;
        req.cell_y      = y;
        req.cell_z      = z;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(op, g, x, y, z);
    endtask

    task automatic drain();
        @(negedge clk);
        req.valid = 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Register write only once the unit has gone idle
    task automatic write_radius(sp3d_pkg::radius_t r);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = r;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.radius = r;
    endtask

    task automatic drop(sp3d_pkg::grain_t g);
        send_item(sp3d_pkg::OP_DROP, g, sp3d_pkg::coord_t'($urandom),
                  sp3d_pkg::coord_t'($urandom), sp3d_pkg::coord_t'($urandom));
    endtask

    task automatic read_cell(sp3d_pkg::coord_t x, sp3d_pkg::coord_t y, sp3d_pkg::coord_t z);
        send_item(sp3d_pkg::OP_READ, sp3d_pkg::grain_t'($urandom), x, y, z);
    endtask

    // Read near the centre of the active cube, now and then anywhere
    task automatic read_nearby();
        int r, c, span;
        r = sb.radius;
        if (r < 1) r = 1;
        if (r > RAD_LIMIT) r = RAD_LIMIT;
        c = r + 1;
        span = (r < 3) ? r + 1 : 3;
        if ($urandom_range(0, 4) == 0)
            read_cell(sp3d_pkg::coord_t'($urandom), sp3d_pkg::coord_t'($urandom),
                      sp3d_pkg::coord_t'($urandom));
        else
            read_cell(sp3d_pkg::coord_t'(c + $urandom_range(0, 2 * span) - span),
                      sp3d_pkg::coord_t'(c + $urandom_range(0, 2 * span) - span),
                      sp3d_pkg::coord_t'(c + $urandom_range(0, 2 * span) - span));
    endtask

    initial
    begin
        sp3d_pkg::radius_t r;
        int                roll;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        req.valid       = 1'b0;
        req.operation   = sp3d_pkg::OP_DROP;
        req.grain_count = '0;
        req.cell_x      = '0;
        req.cell_y      = '0;
        req.cell_z      = '0;
        no_idle         = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset radius, empty grid, topple threshold
        read_cell(5'd15, 5'd15, 5'd15);
        drop(20'd0);
        read_cell(5'd15, 5'd15, 5'd15);
        drop(20'd5);
        read_cell(5'd15, 5'd15, 5'd15);
        drop(20'd6);
        read_cell(5'd15, 5'd15, 5'd15);
        read_cell(5'd16, 5'd15, 5'd15);
        drop(20'd300);
        read_cell(5'd14, 5'd15, 5'd16);

        // Smallest radius, saturated drop spilling over the border
        write_radius(4'd1);
        no_idle = 1'b1;
        drop(20'hFFFFF);
        read_cell(5'd2, 5'd2, 5'd2);
        read_cell(5'd0, 5'd2, 5'd2);
        read_cell(5'd4, 5'd4, 5'd4);
        read_cell(5'd31, 5'd31, 5'd31);
        read_cell(5'd0, 5'd0, 5'd0);
        no_idle = 1'b0;

        // Out-of-range radius values are clamped
        write_radius(4'd0);
        drop(20'd7);
        read_cell(5'd2, 5'd2, 5'd3);
        write_radius(4'd15);
        drop(20'd50);
        read_cell(5'd14, 5'd14, 5'd14);
        read_cell(5'd13, 5'd14, 5'd14);
        write_radius(4'd14);
        drop(20'd100);

        // Random phases: a drop, then mostly reads over the relaxed grid, now and then a drop
        repeat (6)
        begin
            r = sp3d_pkg::radius_t'($urandom);
            write_radius(r);
            no_idle = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 9);
            if (r <= 2 && roll == 0)
                drop(sp3d_pkg::grain_t'($urandom));
            else if (r <= 3)
                drop(sp3d_pkg::grain_t'($urandom_range(0, 3000)));
            else
                drop(sp3d_pkg::grain_t'($urandom_range(0, 250)));
            repeat ($urandom_range(10, 16))
            begin
                if ($urandom_range(0, 19) == 0)
                    drop(sp3d_pkg::grain_t'($urandom_range(0, 60)));
                else
                    read_nearby();
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/sp3d_pkg.sv
rtl/core/sp3d_if.sv
rtl/core/sandpile_3d_relaxation_unit.sv
sim/sandpile_3d_relaxation_unit_tb.sv
